/* rtl/core/ncpc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncpc_pkg
// Types and constants shared by the nearest color pixel classifier: the pixel
// layout, the class codes and the configuration register map.
// ----------------------------------------------------------------------------
package ncpc_pkg;

	localparam int NUM_CLASSES = 4;
	localparam int CLASS_IDX_W = 2;
	localparam int CHAN_W      = 8;
	localparam int SQ_W        = 2 * CHAN_W;
	// Sum of three squared channel differences is at most 195075.
	localparam int DIST_W      = 18;
	localparam int RADIUS_W    = 18;
	localparam int CENTER_W    = 3 * CHAN_W;
	localparam int CFG_IDX_W   = 3;
	localparam int CLASS_W     = 3;

	typedef logic [CHAN_W-1:0]    chan_t;
	typedef logic [SQ_W-1:0]      sq_t;
	typedef logic [DIST_W-1:0]    dist_t;
	typedef logic [RADIUS_W-1:0]  radius_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CLASS_W-1:0]   class_t;

	// Packed so that red sits in the top byte, as R<<16 | G<<8 | B.
	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} rgb_t;

	// Result codes.
	localparam class_t CLASS_RED    = 3'd0;
	localparam class_t CLASS_BLUE   = 3'd1;
	localparam class_t CLASS_YELLOW = 3'd2;
	localparam class_t CLASS_BLACK  = 3'd3;
	localparam class_t CLASS_NONE   = 3'd4;

	// Class slots in the center and radius tables.
	localparam logic [CLASS_IDX_W-1:0] IDX_RED    = 2'd0;
	localparam logic [CLASS_IDX_W-1:0] IDX_BLUE   = 2'd1;
	localparam logic [CLASS_IDX_W-1:0] IDX_YELLOW = 2'd2;
	localparam logic [CLASS_IDX_W-1:0] IDX_BLACK  = 2'd3;

	// Configuration register map.
	localparam cfg_idx_t REG_RED_CENTER    = 3'd0;
	localparam cfg_idx_t REG_BLUE_CENTER   = 3'd1;
	localparam cfg_idx_t REG_YELLOW_CENTER = 3'd2;
	localparam cfg_idx_t REG_BLACK_CENTER  = 3'd3;
	localparam cfg_idx_t REG_RED_RADIUS    = 3'd4;
	localparam cfg_idx_t REG_BLUE_RADIUS   = 3'd5;
	localparam cfg_idx_t REG_YELLOW_RADIUS = 3'd6;
	localparam cfg_idx_t REG_BLACK_RADIUS  = 3'd7;

	function automatic chan_t abs_diff(input chan_t a, input chan_t b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

endpackage
`default_nettype wire

/* rtl/core/nearest_color_pixel_classifier_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_color_pixel_classifier_top
// Sorts RGB pixels into red, blue, yellow, black or no match by squared
// distance to four programmable reference colors.
// ----------------------------------------------------------------------------
// The classifier takes one pixel per clock while in_stall is low and returns
// one class code per pixel, in order. The pipeline has four registered
// stages: an input register, a stage of twelve 8x8 squarers (one per class
// and channel), a stage that adds the three channel terms into an exact
// 18-bit squared distance per class, and the result register that holds the
// priority decision. Each stage holds one pixel and moves on when the stage
// after it is empty or moving, so a result waiting at the output does not
// block new pixels until all four stages are full. The decision uses strict
// less-than throughout: red must beat the other three distances and its
// radius, blue must beat yellow, black and its radius, yellow must beat
// black and its radius, and black must be under its radius; anything else
// is reported as no match. A tie therefore goes to the later class in the
// chain if that class passes its own tests, and a class with radius zero
// never matches. The eight configuration registers (four packed centers,
// four squared radii) reset to zero and are written through the config channel,
// which is always ready; they may only be changed while no pixel is in flight.
// ----------------------------------------------------------------------------
module nearest_color_pixel_classifier_top (
	input  wire                     clk,
	input  wire                     arst_n,
	// Configuration write channel.
	input  wire                     cfg_valid,
	output logic                    cfg_ready,
	input  wire ncpc_pkg::cfg_idx_t cfg_index,
	input  wire [23:0]              cfg_data,
	// Pixel input channel.
	input  wire                     in_valid,
	output logic                    in_stall,
	input  wire ncpc_pkg::chan_t    pixel_red,
	input  wire ncpc_pkg::chan_t    pixel_green,
	input  wire ncpc_pkg::chan_t    pixel_blue,
	// Class output channel.
	output logic                    out_valid,
	input  wire                     out_stall,
	output ncpc_pkg::class_t        color_class
);
	import ncpc_pkg::*;

	// Configuration registers.
	rgb_t    center_q [NUM_CLASSES];
	radius_t radius_q [NUM_CLASSES];

	// Pipeline state.
	logic   v_s1, v_s2, v_s3, out_valid_q;
	rgb_t   pix_s1;
	sq_t    sq_s2 [NUM_CLASSES][3];
	dist_t  dist_s3 [NUM_CLASSES];
	class_t color_class_q;

	// Stage load enables: a stage takes new data when it is empty or when
	// its current contents move on in the same cycle.
	logic en_out, en_s3, en_s2, en_s1;

	assign en_out = !out_valid_q || !out_stall;
	assign en_s3  = !v_s3 || en_out;
	assign en_s2  = !v_s2 || en_s3;
	assign en_s1  = !v_s1 || en_s2;

	assign in_stall    = !en_s1;
	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign color_class = color_class_q;

	// Configuration writes. Radius registers keep the low 18 bits of the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				center_q[i] <= '0;
				radius_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RED_CENTER:    center_q[IDX_RED]    <= cfg_data;
				REG_BLUE_CENTER:   center_q[IDX_BLUE]   <= cfg_data;
				REG_YELLOW_CENTER: center_q[IDX_YELLOW] <= cfg_data;
				REG_BLACK_CENTER:  center_q[IDX_BLACK]  <= cfg_data;
				REG_RED_RADIUS:    radius_q[IDX_RED]    <= cfg_data[RADIUS_W-1:0];
				REG_BLUE_RADIUS:   radius_q[IDX_BLUE]   <= cfg_data[RADIUS_W-1:0];
				REG_YELLOW_RADIUS: radius_q[IDX_YELLOW] <= cfg_data[RADIUS_W-1:0];
				REG_BLACK_RADIUS:  radius_q[IDX_BLACK]  <= cfg_data[RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1)  v_s1        <= in_valid;
			if (en_s2)  v_s2        <= v_s1;
			if (en_s3)  v_s3        <= v_s2;
			if (en_out) out_valid_q <= v_s3;
		end
	end

	// Stage 2 logic: squared channel differences for every class.
	sq_t sq_d [NUM_CLASSES][3];

	always_comb begin
		chan_t dr, dg, db;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			dr = abs_diff(pix_s1.red,   center_q[c].red);
			dg = abs_diff(pix_s1.green, center_q[c].green);
			db = abs_diff(pix_s1.blue,  center_q[c].blue);
			sq_d[c][0] = SQ_W'(dr) * SQ_W'(dr);
			sq_d[c][1] = SQ_W'(dg) * SQ_W'(dg);
			sq_d[c][2] = SQ_W'(db) * SQ_W'(db);
		end
	end

	// Stage 3 logic: full squared distance per class.
	dist_t dist_d [NUM_CLASSES];

	always_comb begin
		for (int c = 0; c < NUM_CLASSES; c++) begin
			dist_d[c] = DIST_W'(sq_s2[c][0]) + DIST_W'(sq_s2[c][1])
				+ DIST_W'(sq_s2[c][2]);
		end
	end

	// Result logic: priority chain with strict comparisons.
	logic   hit_red, hit_blue, hit_yellow, hit_black;
	class_t class_d;

	always_comb begin
		hit_red = (dist_s3[IDX_RED] < dist_s3[IDX_BLUE])
			&& (dist_s3[IDX_RED] < dist_s3[IDX_YELLOW])
			&& (dist_s3[IDX_RED] < dist_s3[IDX_BLACK])
			&& (dist_s3[IDX_RED] < radius_q[IDX_RED]);
		hit_blue = (dist_s3[IDX_BLUE] < dist_s3[IDX_YELLOW])
			&& (dist_s3[IDX_BLUE] < dist_s3[IDX_BLACK])
			&& (dist_s3[IDX_BLUE] < radius_q[IDX_BLUE]);
		hit_yellow = (dist_s3[IDX_YELLOW] < dist_s3[IDX_BLACK])
			&& (dist_s3[IDX_YELLOW] < radius_q[IDX_YELLOW]);
		hit_black = dist_s3[IDX_BLACK] < radius_q[IDX_BLACK];

		if (hit_red) begin
			class_d = CLASS_RED;
		end else if (hit_blue) begin
			class_d = CLASS_BLUE;
		end else if (hit_yellow) begin
			class_d = CLASS_YELLOW;
		end else if (hit_black) begin
			class_d = CLASS_BLACK;
		end else begin
			class_d = CLASS_NONE;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			pix_s1 <= '{red: pixel_red, green: pixel_green, blue: pixel_blue};
		end
		if (en_s2 && v_s1) begin
			sq_s2 <= sq_d;
		end
		if (en_s3 && v_s2) begin
			dist_s3 <= dist_d;
		end
		if (en_out && v_s3) begin
			color_class_q <= class_d;
		end
	end

	// A stalled input means every stage holds a pixel.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && out_valid_q))
		else $error("input stalled while the pipeline has a free stage");

	// An accepted pixel always lands in the input register.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted pixel was lost at the input register");

	// A class with zero radius can never be reported; checked here for red and black.
	a_red_radius: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && color_class_q == CLASS_RED) |-> (radius_q[IDX_RED] != '0))
		else $error("red reported with zero radius");

	a_black_radius: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && color_class_q == CLASS_BLACK) |-> (radius_q[IDX_BLACK] != '0))
		else $error("black reported with zero radius");

	// Only defined class codes leave the block.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (color_class_q <= CLASS_NONE))
		else $error("undefined class code at the output");

endmodule
`default_nettype wire

/* tb/tb_nearest_color_pixel_classifier_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_color_pixel_classifier_top
// Self-checking bench for the nearest color pixel classifier. Pixels are
// queued by a stimulus process, sent by a clocked driver and classified by a
// behavioral copy of the classifier the moment each input transfer completes.
// A clocked monitor compares every output transfer with the oldest predicted
// class. The run steps through several register settings and several mixes
// of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_nearest_color_pixel_classifier_top;
	import ncpc_pkg::*;

	// Four pipeline stages, so the drain wait covers any result in flight.
	localparam int DRAIN_CYCLES = 8;
	// Cycles the receiver holds off while the sender keeps offering pixels.
	localparam int HOLD_CYCLES  = 64;
	// Watchdog limit, far beyond the length of the slowest correct run.
	localparam int LIMIT_CYCLES = 200000;
	localparam int RANDOM_PHASES    = 8;
	localparam int PIXELS_PER_PHASE = 145;
	localparam int HOLD_PIXELS      = 40;

	// Flavors of register setting used by the random phases.
	localparam int CFG_RANDOM  = 0;
	localparam int CFG_EXTREME = 1;
	localparam int CFG_SHARED  = 2;

	logic     clk;
	logic     arst_n;
	logic     cfg_valid;
	logic     cfg_ready;
	cfg_idx_t cfg_index;
	logic [23:0] cfg_data;
	logic     in_valid;
	logic     in_stall;
	chan_t    pixel_red;
	chan_t    pixel_green;
	chan_t    pixel_blue;
	logic     out_valid;
	logic     out_stall;
	class_t   color_class;

	nearest_color_pixel_classifier_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_red   (pixel_red),
		.pixel_green (pixel_green),
		.pixel_blue  (pixel_blue),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.color_class (color_class)
	);

	// Shadow copy of the configuration registers, updated on every write.
	rgb_t    tab_center [NUM_CLASSES];
	radius_t tab_radius [NUM_CLASSES];

	// Pixels waiting to be sent and classes waiting to come back, in order.
	rgb_t   pixel_backlog [$];
	class_t predicted_classes [$];

	// Percentages of cycles in which the sender idles and the receiver stalls.
	int idle_pct;
	int stall_pct;

	// Long hold-off of the receiver, counted in its own process below.
	logic hold_req;
	int   hold_count;
	wire  holding = hold_req && (hold_count < HOLD_CYCLES);

	int     fail_count;
	int     cycle_count = 0;
	rgb_t   drv_px;
	class_t want_class;

	always #5 clk = ~clk;

	// Behavioral classifier. The squared distances are exact and never exceed
	// 195075, so they fit the 18-bit distance type without loss. The priority
	// chain uses strict less-than everywhere, which makes ties fall through to
	// a later class, and a zero radius can never be beaten.
	function automatic class_t classify_pixel(input rgb_t px);
		dist_t d [NUM_CLASSES];
		int    dr, dg, db;
		for (int k = 0; k < NUM_CLASSES; k++) begin
			dr = int'(px.red) - int'(tab_center[k].red);
			dg = int'(px.green) - int'(tab_center[k].green);
			db = int'(px.blue) - int'(tab_center[k].blue);
			d[k] = dist_t'(dr * dr + dg * dg + db * db);
		end
		if (d[IDX_RED] < d[IDX_BLUE] && d[IDX_RED] < d[IDX_YELLOW] &&
				d[IDX_RED] < d[IDX_BLACK] && d[IDX_RED] < tab_radius[IDX_RED])
			return CLASS_RED;
		if (d[IDX_BLUE] < d[IDX_YELLOW] && d[IDX_BLUE] < d[IDX_BLACK] &&
				d[IDX_BLUE] < tab_radius[IDX_BLUE])
			return CLASS_BLUE;
		if (d[IDX_YELLOW] < d[IDX_BLACK] && d[IDX_YELLOW] < tab_radius[IDX_YELLOW])
			return CLASS_YELLOW;
		if (d[IDX_BLACK] < tab_radius[IDX_BLACK])
			return CLASS_BLACK;
		return CLASS_NONE;
	endfunction

	// Pixel driver. The class of a pixel is predicted at the edge where its
	// transfer completes. A stalled pixel stays on the port unchanged; the
	// decision to idle is only taken when a new pixel could be offered, so
	// valid never reacts to stall.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predicted_classes.push_back(
					classify_pixel('{red: pixel_red, green: pixel_green, blue: pixel_blue}));
			end
			if (!in_valid || !in_stall) begin
				if (pixel_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					drv_px = pixel_backlog.pop_front();
					in_valid    <= 1'b1;
					pixel_red   <= drv_px.red;
					pixel_green <= drv_px.green;
					pixel_blue  <= drv_px.blue;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor. Every output transfer must match the oldest prediction.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (predicted_classes.size() == 0) begin
					$display("%0t: unexpected color_class, expected nothing, got %0d",
						$time, color_class);
					fail_count++;
				end else begin
					want_class = predicted_classes.pop_front();
					if (color_class !== want_class) begin
						$display("%0t: color_class mismatch, expected %0d, got %0d",
							$time, want_class, color_class);
						fail_count++;
					end
				end
			end
			out_stall <= holding || ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Hold-off counter: once requested, the receiver stalls until this count reaches HOLD_CYCLES.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_count <= 0;
		end else if (holding) begin
			hold_count <= hold_count + 1;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// One register write; the shadow copy masks the radius to its width.
	task automatic write_reg(input cfg_idx_t idx, input logic [23:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx <= REG_BLACK_CENTER) begin
			tab_center[idx[CLASS_IDX_W-1:0]] = data;
		end else begin
			tab_radius[idx[CLASS_IDX_W-1:0]] = data[RADIUS_W-1:0];
		end
	endtask

	// Returns once every queued pixel has been sent, every class has come back
	// and the pipeline has had time to empty. Registers may change after this.
	task automatic wait_drained();
		do @(negedge clk);
		while (pixel_backlog.size() != 0 || in_valid || predicted_classes.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_traffic(input int idle, input int stall);
		@(posedge clk);
		idle_pct  <= idle;
		stall_pct <= stall;
	endtask

	// Programs all eight registers. Radius writes carry random upper bits in
	// the data word, which the block must drop.
	task automatic program_config(input int flavor);
		rgb_t        c [NUM_CLASSES];
		radius_t     r;
		logic [23:0] d;
		int          pick;
		for (int k = 0; k < NUM_CLASSES; k++) begin
			case (flavor)
				CFG_EXTREME: begin
					c[k] = (k % 2 == 1) ? '1 : '0;
				end
				CFG_SHARED: begin
					c[k] = (k == 0) ? rgb_t'($urandom) : c[0];
				end
				default: begin
					// Now and then reuse an earlier center to force exact ties.
					if (k > 0 && $urandom_range(0, 4) == 0)
						c[k] = c[$urandom_range(0, k - 1)];
					else
						c[k] = rgb_t'($urandom);
				end
			endcase
			write_reg(REG_RED_CENTER + cfg_idx_t'(k), c[k]);
		end
		for (int k = 0; k < NUM_CLASSES; k++) begin
			pick = $urandom_range(0, 5);
			if (flavor == CFG_EXTREME)
				r = (k == IDX_YELLOW) ? '0 : '1;
			else if (pick == 0)
				r = '0;
			else if (pick == 1)
				r = '1;
			else if (pick < 4)
				r = radius_t'($urandom_range(0, 20000));
			else
				r = radius_t'($urandom);
			d = 24'($urandom);
			d[RADIUS_W-1:0] = r;
			write_reg(REG_RED_RADIUS + cfg_idx_t'(k), d);
		end
	endtask

	// Queues random pixels. Most sit close to a center, on a center, or on the
	// midpoint of two centers, so that matches, radius edges and ties all
	// happen; the rest are uniformly random.
	task automatic queue_pixels(input int count);
		rgb_t a, b, px;
		int   pick, spread, v;
		@(negedge clk);
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			a = tab_center[$urandom_range(0, NUM_CLASSES - 1)];
			b = tab_center[$urandom_range(0, NUM_CLASSES - 1)];
			px = rgb_t'($urandom);
			if (pick < 50) begin
				spread = ($urandom_range(0, 3) == 0) ? 64 : 12;
				for (int ch = 0; ch < 3; ch++) begin
					v = int'(a[8*ch +: 8]) + int'($urandom_range(0, 2 * spread)) - spread;
					if (v < 0) v = 0;
					if (v > 255) v = 255;
					px[8*ch +: 8] = v[7:0];
				end
			end else if (pick < 65) begin
				for (int ch = 0; ch < 3; ch++)
					px[8*ch +: 8] = 8'((int'(a[8*ch +: 8]) + int'(b[8*ch +: 8])) / 2);
			end else if (pick < 75) begin
				px = a;
			end
			pixel_backlog.push_back(px);
		end
	endtask

	initial begin
		logic [23:0] primary_px [16] = '{
			24'h000000, 24'hFFFFFF, 24'hC80000, 24'h0000C8,
			24'hC8C800, 24'h00FF00, 24'hFF00FF, 24'h808080,
			24'h7F7F7F, 24'h640000, 24'h000064, 24'h646400,
			24'h640064, 24'h00FFFF, 24'h010101, 24'hFEFEFE
		};
		clk         = 1'b0;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_RED_CENTER;
		cfg_data    = '0;
		in_valid    = 1'b0;
		pixel_red   = '0;
		pixel_green = '0;
		pixel_blue  = '0;
		out_stall   = 1'b0;
		hold_req    = 1'b0;
		idle_pct    = 0;
		stall_pct   = 0;
		fail_count  = 0;
		for (int k = 0; k < NUM_CLASSES; k++) begin
			tab_center[k] = '0;
			tab_radius[k] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Straight after reset every radius is zero, so nothing may match.
		@(negedge clk);
		pixel_backlog.push_back(rgb_t'(24'h000000));
		pixel_backlog.push_back(rgb_t'(24'hFFFFFF));
		wait_drained();

		// Hand-picked centers 200 apart along the axes, so that points at
		// distance 100 tie two or more classes exactly. The radius writes use an
		// all-ones data word, which must be cut to the largest 18-bit radius.
		write_reg(REG_RED_CENTER, 24'hC80000);
		write_reg(REG_BLUE_CENTER, 24'h0000C8);
		write_reg(REG_YELLOW_CENTER, 24'hC8C800);
		write_reg(REG_BLACK_CENTER, 24'h000000);
		write_reg(REG_RED_RADIUS, 24'hFFFFFF);
		write_reg(REG_BLUE_RADIUS, 24'hFFFFFF);
		write_reg(REG_YELLOW_RADIUS, 24'hFFFFFF);
		write_reg(REG_BLACK_RADIUS, 24'hFFFFFF);
		@(negedge clk);
		foreach (primary_px[i])
			pixel_backlog.push_back(rgb_t'(primary_px[i]));
		wait_drained();

		// Red radius of exactly 100 squared: a pixel at that distance must miss
		// red, one a step closer must hit it.
		write_reg(REG_RED_RADIUS, 24'd10000);
		@(negedge clk);
		pixel_backlog.push_back(rgb_t'(24'hC80064));
		pixel_backlog.push_back(rgb_t'(24'hC80063));
		wait_drained();

		// The receiver holds off while the sender keeps pushing, so the pipeline
		// fills and the input stall has to rise. Afterwards the sender waits for
		// every class to come back.
		set_traffic(0, 0);
		program_config(CFG_RANDOM);
		@(posedge clk);
		hold_req <= 1'b1;
		queue_pixels(HOLD_PIXELS);
		do @(negedge clk); while (hold_count < HOLD_CYCLES);
		@(posedge clk);
		hold_req <= 1'b0;
		wait_drained();

		// Random phases rotate through the traffic mixes and register flavors.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p % 4)
				0: set_traffic(0, 0);
				1: set_traffic(71, 0);
				2: set_traffic(0, 71);
				default: set_traffic(18, 18);
			endcase
			if (p == 1)
				program_config(CFG_EXTREME);
			else if (p == 5)
				program_config(CFG_SHARED);
			else
				program_config(CFG_RANDOM);
			queue_pixels(PIXELS_PER_PHASE);
			wait_drained();
		end

		@(negedge clk);
		if (fail_count == 0 && predicted_classes.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
